// File: sv/rrts_pkg.sv
package rrts_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned PtrW     = $clog2(MaxTasks);
  localparam int unsigned CntW     = $clog2(MaxTasks + 1);

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [15:0] QuantumReset = 16'd1;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_RAN    = 3'd1,
    ST_FINISH = 3'd2,
    ST_ACCEPT = 3'd3,
    ST_DROP   = 3'd4
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  task_id;
    logic [15:0] burst;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  task_id_out;
    logic [31:0] time_now;
  } result_t;

  function automatic ptr_t ring_next(input ptr_t p);
    if (p == ptr_t'(MaxTasks - 1)) begin
      return '0;
    end else begin
      return p + ptr_t'(1);
    end
  endfunction

endpackage

// File: sv/rrts_in_if.sv
interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  task_id;
  logic [15:0] burst;

  modport source (output valid, output req_type, output task_id, output burst, input ready);
  modport sink   (input valid, input req_type, input task_id, input burst, output ready);
endinterface

// File: sv/rrts_out_if.sv
interface rrts_out_if;
  logic              valid;
  logic              ready;
  rrts_pkg::status_t status;
  logic [7:0]        task_id_out;
  logic [31:0]       time_now;

  modport source (output valid, output status, output task_id_out, output time_now,
                  input ready);
  modport sink   (input valid, input status, input task_id_out, input time_now,
                  output ready);
endinterface

// File: sv/rrts_engine.sv
module rrts_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rrts_pkg::item_t   item,
  input  logic [15:0]       quantum,
  output rrts_pkg::result_t result
);

  logic [7:0]  id_r  [rrts_pkg::MaxTasks];
  logic [15:0] rem_r [rrts_pkg::MaxTasks];

  rrts_pkg::ptr_t head_r, head_nxt;
  rrts_pkg::ptr_t tail_r, tail_nxt;
  rrts_pkg::cnt_t count_r, count_nxt;
  logic [15:0]    slice_r, slice_nxt;
  logic [31:0]    time_r, time_nxt;

  logic           wr_en;
  rrts_pkg::ptr_t wr_addr;
  logic [7:0]     wr_id;
  logic [15:0]    wr_rem;

  logic [7:0]  head_id;
  logic [15:0] head_rem;
  logic [15:0] rem_dec;
  logic [16:0] slice_inc;

  assign head_id   = id_r[head_r];
  assign head_rem  = rem_r[head_r];
  assign rem_dec   = (head_rem == 16'd0) ? 16'd0 : head_rem - 16'd1;
  assign slice_inc = {1'b0, slice_r} + 17'd1;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    slice_nxt = slice_r;
    time_nxt  = time_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    wr_id     = item.task_id;
    wr_rem    = (item.burst == 16'd0) ? 16'd1 : item.burst;
    result.status      = rrts_pkg::ST_IDLE;
    result.task_id_out = item.task_id;
    result.time_now    = time_r;

    if (item.req_type == rrts_pkg::REQ_ARRIVAL) begin
      if (count_r == rrts_pkg::cnt_t'(rrts_pkg::MaxTasks)) begin
        result.status = rrts_pkg::ST_DROP;
      end else begin
        wr_en         = 1'b1;
        tail_nxt      = rrts_pkg::ring_next(tail_r);
        count_nxt     = count_r + rrts_pkg::cnt_t'(1);
        result.status = rrts_pkg::ST_ACCEPT;
      end
    end else begin
      time_nxt        = time_r + 32'd1;
      result.time_now = time_nxt;
      if (count_r == '0) begin
        slice_nxt          = '0;
        result.task_id_out = 8'd0;
      end else begin
        result.task_id_out = head_id;
        wr_id              = head_id;
        wr_rem             = rem_dec;
        if (rem_dec == 16'd0) begin
          head_nxt      = rrts_pkg::ring_next(head_r);
          count_nxt     = count_r - rrts_pkg::cnt_t'(1);
          slice_nxt     = '0;
          result.status = rrts_pkg::ST_FINISH;
        end else begin
          result.status = rrts_pkg::ST_RAN;
          wr_en         = 1'b1;
          if (slice_inc >= {1'b0, quantum}) begin
            // slice used up: rotate to the tail, remaining time kept
            head_nxt  = rrts_pkg::ring_next(head_r);
            tail_nxt  = rrts_pkg::ring_next(tail_r);
            slice_nxt = '0;
          end else begin
            wr_addr   = head_r;
            slice_nxt = slice_inc[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      slice_r <= '0;
      time_r  <= '0;
    end else if (step) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      slice_r <= slice_nxt;
      time_r  <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      id_r[wr_addr]  <= wr_id;
      rem_r[wr_addr] <= wr_rem;
    end
  end

endmodule

// File: sv/round_robin_task_scheduler_core.sv
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    req_type, task_id, burst
// out_ch   out  valid/ready    status, task_id_out, time_now
// cfg_*    in   cfg_we only    cfg_wdata = quantum
//
// One item per cycle sustained while out_ch is ready. The input register loads at the input transfer and
// the result register, together with the engine state, loads after it; out_ch.valid is driven
// from the result register.
// Synchronous active-low reset empties the queue and clears time; quantum = 1.
// A stalled result holds the input stage, which in turn drops in_ch.ready.
module round_robin_task_scheduler_core (
  input  logic         clk,
  input  logic         rst_n,
  rrts_in_if.sink      in_ch,
  rrts_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  logic [15:0]       quantum_r;
  rrts_pkg::item_t   item_r;
  logic              item_vld_r;
  rrts_pkg::result_t res_r;
  logic              res_vld_r;
  rrts_pkg::result_t res_nxt;
  logic              advance;

  assign advance     = !res_vld_r || out_ch.ready;
  assign in_ch.ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= rrts_pkg::QuantumReset;
    end else if (cfg_we) begin
      quantum_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.req_type <= in_ch.req_type;
      item_r.task_id  <= in_ch.task_id;
      item_r.burst    <= in_ch.burst;
    end
  end

  rrts_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (item_vld_r && advance),
    .item    (item_r),
    .quantum (quantum_r),
    .result  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = res_vld_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.task_id_out = res_r.task_id_out;
  assign out_ch.time_now    = res_r.time_now;

endmodule

// File: sim/round_robin_task_scheduler_core_tb.sv
`timescale 1ns / 1ps

module round_robin_task_scheduler_core_tb;

  localparam int          ClkPeriod   = 4;
  localparam int          HoldCycles  = 300;
  localparam int          DrainCycles = 8;
  localparam int unsigned CycleLimit  = 100000;

  // Directed rows; the expected result is only filled in where typed is set
  typedef struct packed {
    logic              req_type;
    logic [7:0]        task_id;
    logic [15:0]       burst;
    logic              typed;
    rrts_pkg::status_t status;
    logic [7:0]        id_out;
    logic [31:0]       time_now;
  } script_row_t;

  localparam int NumScript = 25;
  localparam script_row_t Script [NumScript] = '{
    '{rrts_pkg::REQ_TICK,    8'h00, 16'h0000, 1'b1, rrts_pkg::ST_IDLE,   8'h00, 32'd1},
    '{rrts_pkg::REQ_ARRIVAL, 8'hFF, 16'h0003, 1'b1, rrts_pkg::ST_ACCEPT, 8'hFF, 32'd1},
    '{rrts_pkg::REQ_ARRIVAL, 8'h00, 16'h0000, 1'b1, rrts_pkg::ST_ACCEPT, 8'h00, 32'd1},
    '{rrts_pkg::REQ_TICK,    8'hA5, 16'h5A5A, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_TICK,    8'h00, 16'h0000, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_TICK,    8'h00, 16'h0000, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_TICK,    8'h00, 16'h0000, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_TICK,    8'h00, 16'h0000, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h01, 16'h0001, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h02, 16'h0002, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h04, 16'h0003, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h08, 16'h0004, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h10, 16'h0005, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h20, 16'h0001, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h40, 16'h0002, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h80, 16'h0003, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h55, 16'h0004, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'hAA, 16'h0005, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h33, 16'h0001, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'hCC, 16'h0002, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h0F, 16'h0006, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'hF0, 16'h0003, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h7E, 16'h0002, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'h81, 16'h0001, 1'b0, rrts_pkg::ST_IDLE,   8'h00, 32'd0},
    '{rrts_pkg::REQ_ARRIVAL, 8'hFF, 16'hFFFF, 1'b1, rrts_pkg::ST_DROP,   8'hFF, 32'd6}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  rrts_in_if  in_ch ();
  rrts_out_if out_ch ();

  round_robin_task_scheduler_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // scheduler mirror
  logic [7:0]     sched_id   [rrts_pkg::MaxTasks];
  logic [15:0]    sched_left [rrts_pkg::MaxTasks];
  rrts_pkg::ptr_t sched_head;
  rrts_pkg::ptr_t sched_tail;
  rrts_pkg::cnt_t sched_count;
  logic [15:0]    sched_slice;
  logic [31:0]    sched_time;
  logic [15:0]    sched_quantum;

  rrts_pkg::result_t pending_results [$];
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned quantum_writes;
  int unsigned outcome_seen [5];
  int          gap_pct;
  int          stall_pct;
  int unsigned hold_req;
  int unsigned hold_ack;

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic rrts_pkg::result_t schedule_step(input rrts_pkg::item_t it);
    rrts_pkg::result_t r;
    logic [15:0]       left;
    int unsigned       run_len;
    r.status      = rrts_pkg::ST_IDLE;
    r.task_id_out = '0;
    r.time_now    = sched_time;
    if (it.req_type == rrts_pkg::REQ_ARRIVAL) begin
      r.task_id_out = it.task_id;
      if (sched_count == rrts_pkg::cnt_t'(rrts_pkg::MaxTasks)) begin
        r.status = rrts_pkg::ST_DROP;
      end else begin
        sched_id[sched_tail]   = it.task_id;
        sched_left[sched_tail] = (it.burst == 16'd0) ? 16'd1 : it.burst;
        sched_tail             = rrts_pkg::ptr_t'((sched_tail + 1) % rrts_pkg::MaxTasks);
        sched_count            = sched_count + 1'b1;
        r.status               = rrts_pkg::ST_ACCEPT;
      end
      return r;
    end
    sched_time = sched_time + 1;
    r.time_now = sched_time;
    if (sched_count == '0) begin
      sched_slice = '0;
      return r;
    end
    r.task_id_out = sched_id[sched_head];
    r.status      = rrts_pkg::ST_RAN;
    left          = (sched_left[sched_head] == 16'd0) ? 16'd0
                                                      : sched_left[sched_head] - 1'b1;
    run_len       = sched_slice + 1;
    if (left == 16'd0) begin
      sched_head  = rrts_pkg::ptr_t'((sched_head + 1) % rrts_pkg::MaxTasks);
      sched_count = sched_count - 1'b1;
      sched_slice = '0;
      r.status    = rrts_pkg::ST_FINISH;
    end else if (run_len >= sched_quantum) begin
      // rotate: when full, the tail slot is the one just vacated by the head
      sched_head             = rrts_pkg::ptr_t'((sched_head + 1) % rrts_pkg::MaxTasks);
      sched_id[sched_tail]   = r.task_id_out;
      sched_left[sched_tail] = left;
      sched_tail             = rrts_pkg::ptr_t'((sched_tail + 1) % rrts_pkg::MaxTasks);
      sched_slice            = '0;
    end else begin
      sched_left[sched_head] = left;
      sched_slice            = run_len[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_burst();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) return 16'($urandom);
    if (roll < 5) return 16'd0;
    if (roll < 25) return 16'($urandom_range(64, 7));
    return 16'($urandom_range(6, 1));
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input rrts_pkg::item_t it, input bit typed,
                           input rrts_pkg::result_t want);
    rrts_pkg::result_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= it.req_type;
    in_ch.task_id  <= it.task_id;
    in_ch.burst    <= it.burst;
    do @(posedge clk); while (!in_ch.ready);
    predicted = schedule_step(it);
    outcome_seen[int'(predicted.status)]++;
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained(input int gap, input int stall);
    do @(posedge clk); while (pending_results.size() != 0);
    gap_pct   = gap;
    stall_pct = stall;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] q, input int gap, input int stall,
                           input int n, input int arrive_pct, input bit long_hold);
    rrts_pkg::item_t it;
    wait_drained(gap, stall);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(negedge clk);
    cfg_we        <= 1'b0;
    sched_quantum  = q;
    quantum_writes++;
    if (long_hold) begin
      @(posedge clk);
      hold_req++;
      @(negedge clk);
    end
    repeat (n) begin
      it.req_type = ($urandom_range(99) < arrive_pct) ? rrts_pkg::REQ_ARRIVAL
                                                      : rrts_pkg::REQ_TICK;
      it.task_id  = 8'($urandom);
      it.burst    = pick_burst();
      send_item(it, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin : result_drain
    int unsigned hold_left;
    hold_left    = 0;
    hold_ack     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rrts_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: status %0d task %0h time %0d",
               out_ch.status, out_ch.task_id_out, out_ch.time_now);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          failures++;
        end
        if (out_ch.task_id_out !== want.task_id_out) begin
          $error("task_id_out: expected %0h, got %0h", want.task_id_out, out_ch.task_id_out);
          failures++;
        end
        if (out_ch.time_now !== want.time_now) begin
          $error("time_now: expected %0d, got %0d", want.time_now, out_ch.time_now);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    rrts_pkg::item_t   it;
    rrts_pkg::result_t want;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = rrts_pkg::REQ_ARRIVAL;
    in_ch.task_id  = '0;
    in_ch.burst    = '0;
    gap_pct        = 0;
    stall_pct      = 0;
    hold_req       = 0;
    items_sent     = 0;
    quantum_writes = 0;
    foreach (outcome_seen[i]) outcome_seen[i] = 0;
    foreach (sched_id[i]) begin
      sched_id[i]   = '0;
      sched_left[i] = '0;
    end
    sched_head    = '0;
    sched_tail    = '0;
    sched_count   = '0;
    sched_slice   = '0;
    sched_time    = '0;
    sched_quantum = rrts_pkg::QuantumReset;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // quantum still at its reset value here
    for (int i = 0; i < NumScript; i++) begin
      it   = '{Script[i].req_type, Script[i].task_id, Script[i].burst};
      want = '{Script[i].status, Script[i].id_out, Script[i].time_now};
      send_item(it, Script[i].typed, want);
    end
    in_ch.valid <= 1'b0;

    run_phase(16'hFFFF, 0,  0,  70, 20, 1'b0);
    run_phase(16'h0000, 66, 0,  70, 35, 1'b0);
    run_phase(16'd2,    0,  66, 70, 30, 1'b0);
    run_phase(16'd3,    6,  6,  70, 25, 1'b0);
    run_phase(16'($urandom_range(8, 1)), 0, 0, 50, 30, 1'b1);
    run_phase(16'd1,    0,  0,  50, 40, 1'b0);

    wait_drained(0, 0);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d items over %0d quantum settings (zero, one, small, max), with sender gaps,",
             items_sent, quantum_writes);
    $display("receiver stalls and a long hold-off: %0d idle, %0d ran, %0d finished,",
             outcome_seen[0], outcome_seen[1], outcome_seen[2]);
    $display("%0d in, %0d dropped", outcome_seen[3], outcome_seen[4]);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
